### hdl/matrix_vector_dot_accumulate_assert.svh
// assertion macros shared by the rtl files
`ifndef MATRIX_VECTOR_DOT_ACCUMULATE_ASSERT_SVH
`define MATRIX_VECTOR_DOT_ACCUMULATE_ASSERT_SVH

// same-cycle implication
`define MVDA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication
`define MVDA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

### hdl/mvda_pkg.sv
`default_nettype none
package mvda_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
   localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;

   localparam logic CSR_WEIGHT_IS_BF16 = 1'b0;
   localparam logic CSR_BIAS_ENABLE = 1'b1;

   // product transaction handed from front to back
   typedef struct packed {
      logic        valid;
      logic [31:0] prod;
      logic [31:0] bias;
      logic        row_end;
   } entry_type;

   // leading zero count over 49 bits, 49 for an all-zero word
   function automatic logic [5:0] lzc49(input logic [48:0] x);
      logic [5:0] n;
      n = 6'd49;
      for (int i = 0; i < 49; i++) begin
         if (x[i]) n = 6'(48 - i);
      end
      return n;
   endfunction

   // round to nearest even and pack; x has its msb at bit 47 unless zero
   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                              input logic [47:0] x);
      logic [47:0]        xs;
      logic signed [11:0] ee;
      logic [11:0]        sh;
      logic               lost;
      logic [23:0]        mant;
      logic               g;
      logic               st;
      logic               inc;
      logic [24:0]        m25;
      logic [34:0]        big;
      xs   = x;
      ee   = e;
      lost = 1'b0;
      if (e < 12'sd1) begin
         sh = 12'(12'sd1 - e);
         if (sh >= 12'd48) begin
            lost = |x;
            xs   = '0;
         end else begin
            lost = |(x & ((48'd1 << sh) - 48'd1));
            xs   = x >> sh;
         end
         ee = 12'sd1;
      end
      mant = xs[47:24];
      g    = xs[23];
      st   = (|xs[22:0]) | lost;
      inc  = g & (st | mant[0]);
      m25  = {1'b0, mant} + {24'd0, inc};
      big  = {12'(ee - 12'sd1), 23'd0} + {10'd0, m25};
      if (x == 48'd0) return {s, 31'd0};
      if (big >= {4'd0, 8'hFF, 23'd0}) return {s, 8'hFF, 23'd0};
      return {s, big[30:0]};
   endfunction

   // fp32 add, one rounding, canonical nan
   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic        a_nan, b_nan, a_inf, b_inf, swap, sb, ss;
      logic [31:0] hi, lo;
      logic [7:0]  eh, el, d;
      logic [23:0] mh, ml;
      logic [47:0] xv, yv;
      logic        sticky;
      logic [48:0] sum, sn;
      logic [5:0]  lz;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      swap   = b[30:0] > a[30:0];
      hi     = swap ? b : a;
      lo     = swap ? a : b;
      ss     = hi[31];
      sb     = lo[31];
      eh     = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
      el     = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
      mh     = {hi[30:23] != 8'd0, hi[22:0]};
      ml     = {lo[30:23] != 8'd0, lo[22:0]};
      d      = eh - el;
      xv     = {mh, 24'd0};
      yv     = {ml, 24'd0};
      if (d >= 8'd48) begin
         sticky = |ml;
         yv     = '0;
      end else begin
         sticky = |(yv & ((48'd1 << d) - 48'd1));
         yv     = yv >> d;
      end
      yv[0]  = yv[0] | sticky;
      sum    = (ss == sb) ? ({1'b0, xv} + {1'b0, yv}) : ({1'b0, xv} - {1'b0, yv});
      lz     = lzc49(sum);
      sn     = sum << lz;
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return FP_QNAN;
      if (a_inf) return a;
      if (b_inf) return b;
      if (sum == 49'd0) return {a[31] & b[31], 31'd0};
      return round_pack(ss, 12'($signed({4'd0, eh})) + 12'sd1 - 12'($signed({6'd0, lz})),
                        {sn[48:2], sn[1] | sn[0]});
   endfunction

endpackage
`default_nettype wire

### hdl/mvda_front.sv
`default_nettype none
module mvda_front #(
   parameter int QUEUE_DEPTH = mvda_pkg::QUEUE_DEPTH,
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                weight_is_bf16,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [31:0]         req_act_value,
   input  wire logic [31:0]         req_weight_value,
   input  wire logic [31:0]         req_bias_value,
   input  wire logic                req_row_end,
   input  wire logic [LVL_W-1:0]    queue_level,
   output mvda_pkg::entry_type      push
);
   import mvda_pkg::*;

   logic [31:0] wv;
   logic        act_nan, wt_nan, act_inf, wt_inf, act_zero, wt_zero;
   logic [7:0]  ea, eb;

   logic               f1_valid_ff, f1_valid_in;
   logic [47:0]        f1_prod_ff, f1_prod_in;
   logic signed [11:0] f1_exp_ff, f1_exp_in;
   logic               f1_sign_ff, f1_nan_ff, f1_inf_ff;
   logic [31:0]        f1_bias_ff;
   logic               f1_row_end_ff;

   logic [5:0]  lz;
   logic [47:0] pn;

   // credit check: queue entries plus the one product in flight
   assign req_ready = ({1'b0, queue_level} + {{LVL_W{1'b0}}, f1_valid_ff})
                      < (LVL_W + 1)'(QUEUE_DEPTH);

   // operand classification and mantissa product
   assign wv       = weight_is_bf16 ? {req_weight_value[15:0], 16'd0} : req_weight_value;
   assign act_nan  = (req_act_value[30:23] == 8'hFF) && (req_act_value[22:0] != 23'd0);
   assign wt_nan   = (wv[30:23] == 8'hFF) && (wv[22:0] != 23'd0);
   assign act_inf  = (req_act_value[30:23] == 8'hFF) && (req_act_value[22:0] == 23'd0);
   assign wt_inf   = (wv[30:23] == 8'hFF) && (wv[22:0] == 23'd0);
   assign act_zero = req_act_value[30:0] == 31'd0;
   assign wt_zero  = wv[30:0] == 31'd0;
   assign ea       = (req_act_value[30:23] == 8'd0) ? 8'd1 : req_act_value[30:23];
   assign eb       = (wv[30:23] == 8'd0) ? 8'd1 : wv[30:23];
   assign f1_valid_in = req_valid && req_ready;
   assign f1_prod_in  = {24'd0, req_act_value[30:23] != 8'd0, req_act_value[22:0]}
                        * {24'd0, wv[30:23] != 8'd0, wv[22:0]};
   assign f1_exp_in   = 12'($signed({4'd0, ea})) + 12'($signed({4'd0, eb})) - 12'sd126;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
      if (f1_valid_in) begin
         f1_prod_ff    <= f1_prod_in;
         f1_exp_ff     <= f1_exp_in;
         f1_sign_ff    <= req_act_value[31] ^ wv[31];
         f1_nan_ff     <= act_nan || wt_nan || (act_inf && wt_zero) || (wt_inf && act_zero);
         f1_inf_ff     <= act_inf || wt_inf;
         f1_bias_ff    <= weight_is_bf16 ? {req_bias_value[15:0], 16'd0} : req_bias_value;
         f1_row_end_ff <= req_row_end;
      end
   end

   // normalize and round the product into the queue
   assign lz = lzc49({f1_prod_ff, 1'b0});
   assign pn = f1_prod_ff << lz;

   always_comb begin
      push.valid   = f1_valid_ff;
      push.bias    = f1_bias_ff;
      push.row_end = f1_row_end_ff;
      if (f1_nan_ff) begin
         push.prod = FP_QNAN;
      end else if (f1_inf_ff) begin
         push.prod = {f1_sign_ff, 8'hFF, 23'd0};
      end else begin
         push.prod = round_pack(f1_sign_ff, f1_exp_ff - 12'($signed({6'd0, lz})), pn);
      end
   end
endmodule
`default_nettype wire

### hdl/mvda_queue.sv
`default_nettype none
module mvda_queue #(
   parameter int QUEUE_DEPTH = mvda_pkg::QUEUE_DEPTH,
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1),
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  mvda_pkg::entry_type   push,
   input  wire logic             pop,
   output mvda_pkg::entry_type   head,
   output logic [LVL_W-1:0]      level
);
   import mvda_pkg::*;

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [LVL_W-1:0] level_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ptr_ff] <= push;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop) rd_ptr_ff <= bump(rd_ptr_ff);
         if (push.valid && !pop) level_ff <= level_ff + LVL_W'(1);
         else if (pop && !push.valid) level_ff <= level_ff - LVL_W'(1);
      end
   end

   always_comb begin
      head       = mem_ff[rd_ptr_ff];
      head.valid = level_ff != '0;
   end
   assign level = level_ff;

`include "matrix_vector_dot_accumulate_assert.svh"
   `MVDA_ASSERT_NOW(no_overflow, clock, reset, push.valid && !pop, level_ff != LVL_W'(QUEUE_DEPTH))
   `MVDA_ASSERT_NOW(no_underflow, clock, reset, pop, level_ff != '0)
   `MVDA_ASSERT_NEXT(level_grows, clock, reset, push.valid && !pop, level_ff == $past(level_ff) + LVL_W'(1))
endmodule
`default_nettype wire

### hdl/mvda_back.sv
`default_nettype none
module mvda_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           bias_enable,
   input  mvda_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [31:0]         rsp_row_sum
);
   import mvda_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [31:0] sum;
   logic        s1_valid_ff;
   logic [31:0] s1_sum_ff, s1_bias_ff;
   logic        s1_bias_en_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_row_sum_ff;
   logic        out_move, s1_free, s1_load;

   // stage flow: output register, then the bias stage, then the queue head
   assign out_move = !rsp_valid_ff || rsp_ready;
   assign s1_free  = !s1_valid_ff || out_move;
   assign pop      = head.valid && (!head.row_end || s1_free);
   assign s1_load  = pop && head.row_end;

   // running sum
   assign sum    = fp_add(acc_ff, head.prod);
   assign acc_in = head.row_end ? FP_POS_ZERO : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= FP_POS_ZERO;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) acc_ff <= acc_in;
         if (s1_load) s1_valid_ff <= 1'b1;
         else if (out_move) s1_valid_ff <= 1'b0;
         if (out_move) rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_load) begin
         s1_sum_ff     <= sum;
         s1_bias_ff    <= head.bias;
         s1_bias_en_ff <= bias_enable;
      end
      if (out_move && s1_valid_ff) begin
         rsp_row_sum_ff <= s1_bias_en_ff ? fp_add(s1_sum_ff, s1_bias_ff) : s1_sum_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row_sum = rsp_row_sum_ff;

`include "matrix_vector_dot_accumulate_assert.svh"
   `MVDA_ASSERT_NEXT(acc_cleared, clock, reset, s1_load, acc_ff == FP_POS_ZERO)
   `MVDA_ASSERT_NEXT(bias_stage_full, clock, reset, s1_load, s1_valid_ff)
   `MVDA_ASSERT_NOW(no_row_end_when_blocked, clock, reset, pop && head.row_end, s1_free)
endmodule
`default_nettype wire

### hdl/matrix_vector_dot_accumulate.sv
// matrix-vector dot accumulate: streams one matrix row element per transaction.
// req channel carries an fp32 activation, a weight (fp32, or bf16 in bits 15..0
// when weight_is_bf16 is set), a bias in the weight format and row_end.
// each product is rounded to fp32 and added, rounded, to a running fp32 sum.
// a transaction with row_end set finishes the row: the sum, plus the bias when
// bias_enable is set, goes out on the rsp channel and the sum returns to +0.0.
// throughput: one transaction per cycle until a receiver stall fills the queue,
// set by the back end's accumulate adder, which closes the loop on the running sum.
// a row_end transaction passes the multiply stage, rounding into the queue, the
// accumulate into the bias stage and the bias add into the output register.
// csr writes (index 0 weight_is_bf16, index 1 bias_enable) take effect at once;
// the user must make them only while the block is idle; the block does not enforce it.
// reset (synchronous) clears the sum to +0.0, empties the queue and drops rsp_valid.
// when the receiver stalls, results wait in the output register and bias stage;
// the queue fills and req_ready falls once its entries plus the product in flight reach its depth.
`default_nettype none
module matrix_vector_dot_accumulate #(
   parameter int QUEUE_DEPTH = mvda_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_act_value,
   input  wire logic [31:0] req_weight_value,
   input  wire logic [31:0] req_bias_value,
   input  wire logic        req_row_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_row_sum,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic        csr_write_data
);
   import mvda_pkg::*;

   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   logic             weight_is_bf16_ff;
   logic             bias_enable_ff;
   entry_type        push, head;
   logic             pop;
   logic [LVL_W-1:0] level;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_is_bf16_ff <= 1'b0;
         bias_enable_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WEIGHT_IS_BF16: weight_is_bf16_ff <= csr_write_data;
            CSR_BIAS_ENABLE:    bias_enable_ff    <= csr_write_data;
            default:            ;
         endcase
      end
   end

   mvda_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .weight_is_bf16   (weight_is_bf16_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_act_value    (req_act_value),
      .req_weight_value (req_weight_value),
      .req_bias_value   (req_bias_value),
      .req_row_end      (req_row_end),
      .queue_level      (level),
      .push             (push)
   );

   mvda_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .level (level)
   );

   mvda_back u_back (
      .clock       (clock),
      .reset       (reset),
      .bias_enable (bias_enable_ff),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_row_sum (rsp_row_sum)
   );
endmodule
`default_nettype wire
